// File: rtl/rurnd_pkg.sv
package rurnd_pkg;

    // Field widths
    localparam int unsigned WORD_W  = 64;
    localparam int unsigned HALF_W  = 32;

    // Default depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    // splitmix64 constants
    localparam logic [WORD_W-1:0] MIX_ADD  = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [WORD_W-1:0] MIX_MUL1 = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [WORD_W-1:0] MIX_MUL2 = 64'h94D0_49BB_1331_11EB;
    localparam int unsigned MIX_SH0 = 30;
    localparam int unsigned MIX_SH1 = 27;
    localparam int unsigned MIX_SH2 = 31;

    // xoroshiro128++ rotation and shift amounts
    localparam int unsigned ROT_OUT = 17;
    localparam int unsigned ROT_A   = 49;
    localparam int unsigned SHIFT_A = 21;
    localparam int unsigned ROT_B   = 28;

    // Seed after reset
    localparam logic [WORD_W-1:0] SEED_RESET = 64'd1;

    // One classified item as it travels from front to back
    typedef struct packed {
        logic [WORD_W-1:0] bits;   // pattern, upper half cleared for binary32
        logic              dbl;    // binary64 format
        logic              nz;     // nonzero magnitude, draws a random bit
    } item_t;

    // Generator reload from the seed mixer
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word;
    } gen_load_t;

    // Seed mixer sequence: three partial products per multiply
    typedef enum logic [2:0] {
        MIX_IDLE,
        MIX_M1_LL,
        MIX_M1_LH,
        MIX_M1_HL,
        MIX_M2_LL,
        MIX_M2_LH,
        MIX_M2_HL
    } mix_state_t;

    // Elaboration-time splitmix64, used for the reset state only
    function automatic logic [WORD_W-1:0] splitmix64(input logic [WORD_W-1:0] s);
        logic [WORD_W-1:0] z;
        z = s + MIX_ADD;
        z = (z ^ (z >> MIX_SH0)) * MIX_MUL1;
        z = (z ^ (z >> MIX_SH1)) * MIX_MUL2;
        return z ^ (z >> MIX_SH2);
    endfunction

    localparam logic [WORD_W-1:0] GEN_RESET = splitmix64(SEED_RESET);

endpackage

// File: rtl/rurnd_front.sv
module rurnd_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,   // value_bits
    input  logic                  s_tuser,   // is_double
    input  logic                  mix_busy,
    output logic                  q_valid,
    input  logic                  q_ready,
    output rurnd_pkg::item_t      q_item
);

    logic             valid_reg;
    logic             valid_next;
    rurnd_pkg::item_t item_reg;
    rurnd_pkg::item_t item_next;
    logic             accept;

    // Hold off new items while the generator is being reseeded
    assign s_tready = !mix_busy && (!valid_reg || q_ready);
    assign accept   = s_tvalid && s_tready;

    // Classify: mask to format width and flag nonzero magnitude
    always_comb begin
        item_next.dbl  = s_tuser;
        item_next.bits = s_tuser ? s_tdata : {32'd0, s_tdata[31:0]};
        item_next.nz   = s_tuser ? (s_tdata[62:0] != 63'd0) : (s_tdata[30:0] != 31'd0);
    end

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (q_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

    assign q_valid = valid_reg;
    assign q_item  = item_reg;

endmodule

// File: rtl/rurnd_queue.sv
module rurnd_queue #(
    parameter int unsigned DEPTH = rurnd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  rurnd_pkg::item_t in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output rurnd_pkg::item_t out_item
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rurnd_pkg::item_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Advance pointers with wrap at the queue depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: rtl/rurnd_seed_mix.sv
module rurnd_seed_mix (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [63:0]           cfg_wr_data,
    output logic                  busy,
    output rurnd_pkg::gen_load_t  gen_load
);

    rurnd_pkg::mix_state_t state_reg;
    rurnd_pkg::mix_state_t state_next;
    logic [63:0] op_reg;
    logic [63:0] op_next;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] product;
    logic [63:0] sum;
    logic [63:0] seed_add;

    // Pick the operand halves for this partial product
    always_comb begin
        case (state_reg)
            rurnd_pkg::MIX_M1_LL: begin
                mul_a = op_reg[31:0];
                mul_b = rurnd_pkg::MIX_MUL1[31:0];
            end
            rurnd_pkg::MIX_M1_LH: begin
                mul_a = op_reg[31:0];
                mul_b = rurnd_pkg::MIX_MUL1[63:32];
            end
            rurnd_pkg::MIX_M1_HL: begin
                mul_a = op_reg[63:32];
                mul_b = rurnd_pkg::MIX_MUL1[31:0];
            end
            rurnd_pkg::MIX_M2_LL: begin
                mul_a = op_reg[31:0];
                mul_b = rurnd_pkg::MIX_MUL2[31:0];
            end
            rurnd_pkg::MIX_M2_LH: begin
                mul_a = op_reg[31:0];
                mul_b = rurnd_pkg::MIX_MUL2[63:32];
            end
            rurnd_pkg::MIX_M2_HL: begin
                mul_a = op_reg[63:32];
                mul_b = rurnd_pkg::MIX_MUL2[31:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // One 32x32 multiplier, accumulate modulo 2^64
    assign product  = 64'(mul_a) * 64'(mul_b);
    assign sum      = (state_reg == rurnd_pkg::MIX_M1_LL || state_reg == rurnd_pkg::MIX_M2_LL)
                      ? product : acc_reg + {product[31:0], 32'd0};
    assign seed_add = cfg_wr_data + rurnd_pkg::MIX_ADD;

    // Next state
    always_comb begin
        case (state_reg)
            rurnd_pkg::MIX_IDLE:  state_next = rurnd_pkg::MIX_IDLE;
            rurnd_pkg::MIX_M1_LL: state_next = rurnd_pkg::MIX_M1_LH;
            rurnd_pkg::MIX_M1_LH: state_next = rurnd_pkg::MIX_M1_HL;
            rurnd_pkg::MIX_M1_HL: state_next = rurnd_pkg::MIX_M2_LL;
            rurnd_pkg::MIX_M2_LL: state_next = rurnd_pkg::MIX_M2_LH;
            rurnd_pkg::MIX_M2_LH: state_next = rurnd_pkg::MIX_M2_HL;
            rurnd_pkg::MIX_M2_HL: state_next = rurnd_pkg::MIX_IDLE;
            default:              state_next = rurnd_pkg::MIX_IDLE;
        endcase
        if (cfg_wr_en) begin
            state_next = rurnd_pkg::MIX_M1_LL;
        end
    end

    // Outputs and datapath updates
    always_comb begin
        busy           = (state_reg != rurnd_pkg::MIX_IDLE);
        gen_load.valid = (state_reg == rurnd_pkg::MIX_M2_HL) && !cfg_wr_en;
        gen_load.word  = sum ^ (sum >> rurnd_pkg::MIX_SH2);
        acc_next       = sum;
        op_next        = op_reg;
        if (cfg_wr_en) begin
            op_next = seed_add ^ (seed_add >> rurnd_pkg::MIX_SH0);
        end else if (state_reg == rurnd_pkg::MIX_M1_HL) begin
            op_next = sum ^ (sum >> rurnd_pkg::MIX_SH1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rurnd_pkg::MIX_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg  <= op_next;
        acc_reg <= acc_next;
    end

endmodule

// File: rtl/rurnd_back.sv
module rurnd_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  rurnd_pkg::item_t      q_item,
    input  rurnd_pkg::gen_load_t  gen_load,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_tdata,   // result_bits
    output logic                  m_tuser    // drew_random
);

    localparam int unsigned DRAW_BIT = rurnd_pkg::WORD_W - rurnd_pkg::ROT_OUT;

    logic [63:0] gen_a_reg;
    logic [63:0] gen_a_next;
    logic [63:0] gen_b_reg;
    logic [63:0] gen_b_next;
    logic        valid_reg;
    logic        valid_next;
    logic [63:0] data_reg;
    logic [63:0] data_next;
    logic        drew_reg;
    logic        pop;
    logic [DRAW_BIT:0] low_sum;
    logic        up;
    logic [63:0] stepped;
    logic [63:0] mixed;

    assign q_ready = !valid_reg || m_tready;
    assign pop     = q_valid && q_ready;

    // Bit 0 of the xoroshiro128++ output: the rotation brings sum bit 47 down to bit 0
    assign low_sum = gen_a_reg[DRAW_BIT:0] + gen_b_reg[DRAW_BIT:0];
    assign up      = low_sum[DRAW_BIT] ^ gen_a_reg[0];

    // Generator step
    assign mixed = gen_a_reg ^ gen_b_reg;
    always_comb begin
        gen_a_next = gen_a_reg;
        gen_b_next = gen_b_reg;
        if (gen_load.valid) begin
            gen_a_next = gen_load.word;
            gen_b_next = gen_load.word;
        end else if (pop && q_item.nz) begin
            gen_a_next = {gen_a_reg[64-rurnd_pkg::ROT_A-1:0], gen_a_reg[63:64-rurnd_pkg::ROT_A]}
                         ^ mixed ^ (mixed << rurnd_pkg::SHIFT_A);
            gen_b_next = {mixed[64-rurnd_pkg::ROT_B-1:0], mixed[63:64-rurnd_pkg::ROT_B]};
        end
    end

    // Step the pattern one ulp up or down, wrap at format width
    always_comb begin
        stepped = up ? q_item.bits + 64'd1 : q_item.bits - 64'd1;
        if (!q_item.dbl) begin
            stepped[63:32] = 32'd0;
        end
        data_next = q_item.nz ? stepped : q_item.bits;
    end

    always_comb begin
        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            gen_a_reg <= rurnd_pkg::GEN_RESET;
            gen_b_reg <= rurnd_pkg::GEN_RESET;
        end else begin
            valid_reg <= valid_next;
            gen_a_reg <= gen_a_next;
            gen_b_reg <= gen_b_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            data_reg <= data_next;
            drew_reg <= q_item.nz;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = drew_reg;

endmodule

// File: rtl/random_updown_ulp_rounding_unit.sv
// Random up/down ulp perturbation of IEEE bit patterns, driven by xoroshiro128++.
// Input stream s_*: tdata carries the bit pattern (binary32 in the low 32 bits),
// tuser selects binary64. Output stream m_*: tdata carries the perturbed pattern,
// tuser is set when the value was nonzero and a random bit was drawn.
// Zeros of either sign pass through and leave the generator untouched.
// Throughput is one item per cycle while m_tready is high and no reseed runs; an
// item passes the input register, the queue and the output register before it
// shows on m_tvalid. The queue between the classifying front and the generator
// back lets each side stall on its own; when the receiver holds m_tready low,
// items collect in the queue and then the front.
// A write on cfg_wr_en loads a new seed; the splitmix64 reload runs on one
// shared 32x32 multiplier, and s_tready stays low while it runs.
// After reset the generator holds splitmix64(1), all channels are empty and
// s_tready is high.
module random_updown_ulp_rounding_unit #(
    parameter int unsigned QUEUE_DEPTH = rurnd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,     // [63:0] value_bits
    input  logic        s_tuser,     // [0] is_double
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,     // [63:0] result_bits
    output logic        m_tuser,     // [0] drew_random
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data
);

    logic                 mix_busy;
    rurnd_pkg::gen_load_t gen_load;
    logic                 fq_valid;
    logic                 fq_ready;
    rurnd_pkg::item_t     fq_item;
    logic                 qb_valid;
    logic                 qb_ready;
    rurnd_pkg::item_t     qb_item;

    rurnd_seed_mix u_seed_mix (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .busy        (mix_busy),
        .gen_load    (gen_load)
    );

    rurnd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .mix_busy (mix_busy),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_item   (fq_item)
    );

    rurnd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    rurnd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_item   (qb_item),
        .gen_load (gen_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
